### rtl/svmga_pkg.sv
`default_nettype none
package svmga_pkg;

	localparam int DIM      = 1024;
	localparam int ADDR_W   = $clog2(DIM);
	localparam int MAX_NNZ  = 256;
	localparam int BUF_AW   = $clog2(MAX_NNZ);
	localparam int FILL_W   = BUF_AW + 1;
	localparam int CNT_W    = 24;
	localparam int VAL_W    = 32;
	localparam int ACC_W    = 48;
	localparam int LAMBDA_W = 31;
	localparam int BUF_W    = ADDR_W + VAL_W;
	localparam int DVD_W    = ACC_W + 1;
	localparam int DCNT_W   = $clog2(DVD_W);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic signed [63:0] Q_ONE = 64'sd65536;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FEAT  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_M_RDB,
		ST_M_RDW,
		ST_M_MUL,
		ST_M_ACC,
		ST_DECIDE,
		ST_U_RDB,
		ST_U_RDA,
		ST_U_WR,
		ST_FIN,
		ST_G_RD,
		ST_G_MUL,
		ST_G_DIV,
		ST_G_SUM
	} state_t;

endpackage
`default_nettype wire

### rtl/svm_gradient_accumulator_core.sv
// channel   dir  signals                         payload
// s_axis    in   tvalid tready tdata tuser tlast elem_index, elem_value / cmd, label_pos
// m_axis    out  tvalid tready tdata tuser       grad_value, grad_index / saturated, overflowed
// apb       in   psel penable pwrite paddr ...   reg_lambda read at address 0, written at any address
//
// a closing element runs a margin pass over the buffered elements, then an update pass
// over them when the sample is active; a gradient read uses the bit-serial divider
// (one quotient bit per cycle over 49 bits)
// clear batch sweeps the accumulators; after reset a sweep zeroes both memories
// a finished result waits in the output register; a read stalls only while it is still full
`default_nettype none
module svm_gradient_accumulator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // elem_index, elem_value, zero pad
	input  wire logic [2:0]  s_axis_tuser,  // cmd, label_pos
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // grad_value, grad_index, zero pad
	output logic [1:0]       m_axis_tuser,  // saturated, overflowed
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW  = svmga_pkg::ADDR_W;
	localparam int BAW = svmga_pkg::BUF_AW;
	localparam int FW  = svmga_pkg::FILL_W;
	localparam int CW  = svmga_pkg::CNT_W;
	localparam int VW  = svmga_pkg::VAL_W;
	localparam int AcW = svmga_pkg::ACC_W;
	localparam int BW  = svmga_pkg::BUF_W;
	localparam int DW  = svmga_pkg::DVD_W;
	localparam int DCW = svmga_pkg::DCNT_W;

	function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		logic signed [63:0] r;
		if (v > hi) r = hi;
		else if (v < lo) r = lo;
		else r = v;
		return r;
	endfunction

	function automatic logic out_of(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (v > hi) || (v < lo);
	endfunction

	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;
	localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] S48_MIN = -64'sh0000_8000_0000_0000;

	svmga_pkg::state_t state_q, state_d;
	svmga_pkg::cmd_t   cmd;

	logic [FW-1:0]     fill_q, k_q;
	logic [CW-1:0]     cnt_q;
	logic              sat_q, ovf_q, label_q, clr_all_q;
	logic [30:0]       lambda_q;
	logic [AW-1:0]     idx_q, clr_addr_q;
	logic signed [31:0] m_q, c_q;
	logic signed [63:0] prod_q;
	logic [DW-1:0]     dq_q;
	logic [CW-1:0]     rem_q;
	logic [DCW-1:0]    dcnt_q;
	logic              neg_q;
	logic              out_valid_q, out_sat_q, out_ovf_q;
	logic [VW-1:0]     out_value_q;
	logic [AW-1:0]     out_index_q;

	logic [VW-1:0]  wmem [svmga_pkg::DIM];
	logic [AcW-1:0] amem [svmga_pkg::DIM];
	logic [BW-1:0]  bmem [svmga_pkg::MAX_NNZ];
	logic [VW-1:0]  w_rd_q;
	logic [AcW-1:0] a_rd_q;
	logic [BW-1:0]  b_rd_q;

	logic           w_we, w_re, a_we, a_re, b_we, b_re;
	logic [AW-1:0]  w_wa, w_ra, a_wa, a_ra;
	logic [VW-1:0]  w_wd;
	logic [AcW-1:0] a_wd;
	logic [BAW-1:0] b_wa, b_ra;

	logic           in_fire, out_free, cfg_we;
	logic [AW-1:0]  in_idx;
	logic [AW-1:0]  b_idx;
	logic signed [31:0] b_val;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p, prod_sh, term_c, msum, diff, asum, data, gsum, qmag;
	logic signed [63:0] m_sat, c_sat, a_sat, g_sat;
	logic signed [63:0] m64, y64;
	logic           active;
	logic [CW:0]    trial;
	logic           ge;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cmd      = svmga_pkg::cmd_t'(s_axis_tuser[1:0]);
	assign in_idx   = s_axis_tdata[AW-1:0];
	assign b_idx    = b_rd_q[BW-1:VW];
	assign b_val    = signed'(b_rd_q[VW-1:0]);

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr == 2'd0) ? {1'b0, lambda_q} : 32'd0;

	assign s_axis_tready = (state_q == svmga_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_index_q, out_value_q};
	assign m_axis_tuser  = {out_ovf_q, out_sat_q};

	// shared multiplier
	always_comb begin
		mul_a = signed'(w_rd_q);
		mul_b = b_val;
		case (state_q)
			svmga_pkg::ST_U_RDA: begin
				mul_a = c_q;
				mul_b = b_val;
			end
			svmga_pkg::ST_G_MUL: begin
				mul_a = signed'({1'b0, lambda_q});
				mul_b = signed'(w_rd_q);
			end
			default: begin
				mul_a = signed'(w_rd_q);
				mul_b = b_val;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// floor shift by 16: the product always fits in bits 63:16
	assign prod_sh = 64'(signed'(prod_q[63:16]));
	assign term_c  = sat_to(prod_sh, S32_MIN, S32_MAX);
	assign m64     = 64'(m_q);
	assign msum    = m64 + term_c;
	assign y64     = label_q ? svmga_pkg::Q_ONE : -svmga_pkg::Q_ONE;
	assign diff    = m64 - y64;
	assign active  = label_q ? (m64 < svmga_pkg::Q_ONE) : (m64 > -svmga_pkg::Q_ONE);
	assign asum    = 64'(signed'(a_rd_q)) + prod_sh;
	assign qmag    = signed'({15'd0, dq_q});
	assign data    = (cnt_q == '0) ? 64'sd0 : (neg_q ? -qmag : qmag);
	assign gsum    = data + prod_sh;

	assign m_sat = sat_to(msum, S32_MIN, S32_MAX);
	assign c_sat = sat_to(diff, S32_MIN, S32_MAX);
	assign a_sat = sat_to(asum, S48_MIN, S48_MAX);
	assign g_sat = sat_to(gsum, S32_MIN, S32_MAX);

	// one restoring division step
	assign trial = {rem_q, dq_q[DW-1]};
	assign ge    = trial >= {1'b0, cnt_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			svmga_pkg::ST_CLR:
				if (clr_addr_q == AW'(svmga_pkg::DIM - 1)) state_d = svmga_pkg::ST_IDLE;
			svmga_pkg::ST_IDLE:
				if (in_fire) begin
					case (cmd)
						svmga_pkg::CMD_FEAT:
							if (s_axis_tlast) state_d = svmga_pkg::ST_M_RDB;
						svmga_pkg::CMD_READ:  state_d = svmga_pkg::ST_G_RD;
						svmga_pkg::CMD_CLEAR: state_d = svmga_pkg::ST_CLR;
						default:              state_d = svmga_pkg::ST_IDLE;
					endcase
				end
			svmga_pkg::ST_M_RDB:
				state_d = (k_q == fill_q) ? svmga_pkg::ST_DECIDE : svmga_pkg::ST_M_RDW;
			svmga_pkg::ST_M_RDW: state_d = svmga_pkg::ST_M_MUL;
			svmga_pkg::ST_M_MUL: state_d = svmga_pkg::ST_M_ACC;
			svmga_pkg::ST_M_ACC: state_d = svmga_pkg::ST_M_RDB;
			svmga_pkg::ST_DECIDE:
				state_d = active ? svmga_pkg::ST_U_RDB : svmga_pkg::ST_FIN;
			svmga_pkg::ST_U_RDB:
				state_d = (k_q == fill_q) ? svmga_pkg::ST_FIN : svmga_pkg::ST_U_RDA;
			svmga_pkg::ST_U_RDA: state_d = svmga_pkg::ST_U_WR;
			svmga_pkg::ST_U_WR:  state_d = svmga_pkg::ST_U_RDB;
			svmga_pkg::ST_FIN:   state_d = svmga_pkg::ST_IDLE;
			svmga_pkg::ST_G_RD:  state_d = svmga_pkg::ST_G_MUL;
			svmga_pkg::ST_G_MUL: state_d = svmga_pkg::ST_G_DIV;
			svmga_pkg::ST_G_DIV:
				if (dcnt_q == DCW'(DW - 1)) state_d = svmga_pkg::ST_G_SUM;
			svmga_pkg::ST_G_SUM:
				if (out_free) state_d = svmga_pkg::ST_IDLE;
			default: state_d = svmga_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		w_we = 1'b0; w_wa = in_idx; w_wd = s_axis_tdata[AW+VW-1:AW];
		w_re = 1'b0; w_ra = b_idx;
		a_we = 1'b0; a_wa = b_idx; a_wd = asum[AcW-1:0];
		a_re = 1'b0; a_ra = b_idx;
		b_we = 1'b0; b_wa = fill_q[BAW-1:0];
		b_re = 1'b0; b_ra = k_q[BAW-1:0];
		case (state_q)
			svmga_pkg::ST_CLR: begin
				a_we = 1'b1;
				a_wa = clr_addr_q;
				a_wd = '0;
				w_we = clr_all_q;
				w_wa = clr_addr_q;
				w_wd = '0;
			end
			svmga_pkg::ST_IDLE: begin
				w_we = in_fire && (cmd == svmga_pkg::CMD_LOAD);
				b_we = in_fire && (cmd == svmga_pkg::CMD_FEAT)
					&& (fill_q < FW'(svmga_pkg::MAX_NNZ));
			end
			svmga_pkg::ST_M_RDB: b_re = 1'b1;
			svmga_pkg::ST_M_RDW: w_re = 1'b1;
			svmga_pkg::ST_U_RDB: b_re = 1'b1;
			svmga_pkg::ST_U_RDA: a_re = 1'b1;
			svmga_pkg::ST_U_WR: begin
				a_we = 1'b1;
				a_wd = a_sat[AcW-1:0];
			end
			svmga_pkg::ST_G_RD: begin
				w_re = 1'b1;
				w_ra = idx_q;
				a_re = 1'b1;
				a_ra = idx_q;
			end
			default: begin
				w_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_wa] <= w_wd;
		if (w_re) w_rd_q <= wmem[w_ra];
		if (a_we) amem[a_wa] <= a_wd;
		if (a_re) a_rd_q <= amem[a_ra];
		if (b_we) bmem[b_wa] <= {in_idx, s_axis_tdata[AW+VW-1:AW]};
		if (b_re) b_rd_q <= bmem[b_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svmga_pkg::ST_CLR;
			clr_addr_q  <= '0;
			clr_all_q   <= 1'b1;
			fill_q      <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			ovf_q       <= 1'b0;
			lambda_q    <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) lambda_q <= pwdata[30:0];
			if ((state_q == svmga_pkg::ST_G_SUM) && out_free) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				svmga_pkg::ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(svmga_pkg::DIM - 1)) clr_all_q <= 1'b0;
				end
				svmga_pkg::ST_IDLE:
					if (in_fire) begin
						k_q <= '0;
						if (cmd == svmga_pkg::CMD_FEAT) begin
							if (fill_q < FW'(svmga_pkg::MAX_NNZ)) fill_q <= fill_q + 1'b1;
							else ovf_q <= 1'b1;
						end
						if (cmd == svmga_pkg::CMD_CLEAR) begin
							cnt_q      <= '0;
							fill_q     <= '0;
							sat_q      <= 1'b0;
							ovf_q      <= 1'b0;
							clr_addr_q <= '0;
							clr_all_q  <= 1'b0;
						end
					end
				svmga_pkg::ST_M_ACC: begin
					k_q <= k_q + 1'b1;
					if (out_of(prod_sh, S32_MIN, S32_MAX) || out_of(msum, S32_MIN, S32_MAX))
						sat_q <= 1'b1;
				end
				svmga_pkg::ST_DECIDE: begin
					k_q <= '0;
					if (active && out_of(diff, S32_MIN, S32_MAX)) sat_q <= 1'b1;
				end
				svmga_pkg::ST_U_WR: begin
					k_q <= k_q + 1'b1;
					if (out_of(asum, S48_MIN, S48_MAX)) sat_q <= 1'b1;
				end
				svmga_pkg::ST_FIN: begin
					fill_q <= '0;
					if (cnt_q != svmga_pkg::CNT_MAX) cnt_q <= cnt_q + 1'b1;
					else sat_q <= 1'b1;
				end
				svmga_pkg::ST_G_MUL: dcnt_q <= '0;
				svmga_pkg::ST_G_DIV: dcnt_q <= dcnt_q + 1'b1;
				svmga_pkg::ST_G_SUM:
					if (out_free && out_of(gsum, S32_MIN, S32_MAX)) sat_q <= 1'b1;
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			svmga_pkg::ST_IDLE:
				if (in_fire) begin
					idx_q   <= in_idx;
					label_q <= s_axis_tuser[2];
					m_q     <= '0;
				end
			svmga_pkg::ST_M_MUL: prod_q <= mul_p;
			svmga_pkg::ST_M_ACC: m_q <= m_sat[31:0];
			svmga_pkg::ST_DECIDE: c_q <= c_sat[31:0];
			svmga_pkg::ST_U_RDA: prod_q <= mul_p;
			svmga_pkg::ST_G_MUL: begin
				prod_q <= mul_p;
				neg_q  <= a_rd_q[AcW-1];
				rem_q  <= '0;
				// magnitude of twice the accumulator
				dq_q   <= a_rd_q[AcW-1] ? DW'(-{a_rd_q[AcW-1], a_rd_q, 1'b0})
					: {a_rd_q, 1'b0};
			end
			svmga_pkg::ST_G_DIV: begin
				rem_q <= ge ? CW'(trial - {1'b0, cnt_q}) : trial[CW-1:0];
				dq_q  <= {dq_q[DW-2:0], ge};
			end
			svmga_pkg::ST_G_SUM:
				if (out_free) begin
					out_value_q <= g_sat[31:0];
					out_index_q <= idx_q;
					out_sat_q   <= sat_q || out_of(gsum, S32_MIN, S32_MAX);
					out_ovf_q   <= ovf_q;
				end
			default: begin
				m_q <= m_q;
			end
		endcase
	end

endmodule
`default_nettype wire
